// File: src/sal_pkg.sv
package sal_pkg;

  localparam int unsigned VALUE_W = 64;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctrl_t;

endpackage

// File: src/sal_cell.sv
module sal_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  sal_pkg::cell_ctrl_t ctrl,
  input  sal_pkg::value_t     ins_value,
  input  sal_pkg::value_t     prev_value,
  input  logic                prev_valid,
  input  logic                prev_lt,
  input  sal_pkg::value_t     next_value,
  input  logic                next_valid,
  output sal_pkg::value_t     value,
  output logic                valid,
  output logic                lt
);

  sal_pkg::value_t value_r;
  sal_pkg::value_t value_nxt;
  logic            valid_r;
  logic            valid_nxt;

  assign lt    = valid_r && (ins_value < value_r);
  assign value = value_r;
  assign valid = valid_r;

  // On insertion, cells holding larger values move up one place and the
  // new value lands in the first cell that is larger or empty.
  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    priority if (ctrl.pop) begin
      value_nxt = next_value;
      valid_nxt = next_valid;
    end else if (ctrl.ins) begin
      priority if (prev_lt) begin
        value_nxt = prev_value;
        valid_nxt = 1'b1;
      end else if (lt || (!valid_r && prev_valid)) begin
        value_nxt = ins_value;
        valid_nxt = 1'b1;
      end else begin
        value_nxt = value_r;
        valid_nxt = valid_r;
      end
    end else begin
      value_nxt = value_r;
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

// File: src/sorter_ascending_load_emit.sv
// Channel  Direction  Ports                                       Handshake
// input    in         in_value, in_last_item                      in_valid / in_ready
// result   out        out_sorted_value, out_last_result,          out_valid / out_ready
//                     out_overflow
//
// Each transfer inserts its value into the cell chain in place. After the closing transfer,
// the set is shifted out of cell 0 at one result per cycle while out_ready is high.
// The input is not ready while a set is being emitted; a set of N values is loaded in N
// transfers and yields one result per kept value, at most MAX_ITEMS. Reset empties every cell
// and clears the overflow flag. A stalled result holds the chain unchanged.
module sorter_ascending_load_emit #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [63:0]      in_value,
  input  logic                    in_last_item,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [63:0]      out_sorted_value,
  output logic                    out_last_result,
  output logic                    out_overflow
);

  sal_pkg::state_t     state_r;
  sal_pkg::state_t     state_nxt;
  logic                dropped_r;
  logic                dropped_nxt;
  sal_pkg::cell_ctrl_t ctrl;
  logic                in_xfer;
  logic                out_xfer;
  logic                full;

  sal_pkg::value_t     cell_value [MAX_ITEMS];
  logic                cell_valid [MAX_ITEMS];
  logic                cell_lt    [MAX_ITEMS];

  assign full     = cell_valid[MAX_ITEMS-1];
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  assign out_sorted_value = cell_value[0];
  assign out_last_result  = !cell_valid[1];
  assign out_overflow     = dropped_r;

  always_comb begin
    state_nxt   = state_r;
    dropped_nxt = dropped_r;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    ctrl.ins    = 1'b0;
    ctrl.pop    = 1'b0;
    unique case (state_r)
      sal_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_xfer) begin
          ctrl.ins = !full;
          if (full) begin
            dropped_nxt = 1'b1;
          end
          if (in_last_item) begin
            state_nxt = sal_pkg::ST_EMIT;
          end
        end
      end
      sal_pkg::ST_EMIT: begin
        out_valid = cell_valid[0];
        if (out_xfer) begin
          ctrl.pop = 1'b1;
          if (out_last_result) begin
            state_nxt   = sal_pkg::ST_LOAD;
            dropped_nxt = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = sal_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sal_pkg::ST_LOAD;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    sal_pkg::value_t prev_value;
    logic            prev_valid;
    logic            prev_lt;
    sal_pkg::value_t next_value;
    logic            next_valid;

    if (i == 0) begin : g_first
      assign prev_value = '0;
      assign prev_valid = 1'b1;
      assign prev_lt    = 1'b0;
    end else begin : g_mid
      assign prev_value = cell_value[i-1];
      assign prev_valid = cell_valid[i-1];
      assign prev_lt    = cell_lt[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_last
      assign next_value = '0;
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_value = cell_value[i+1];
      assign next_valid = cell_valid[i+1];
    end

    sal_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .ins_value  (in_value),
      .prev_value (prev_value),
      .prev_valid (prev_valid),
      .prev_lt    (prev_lt),
      .next_value (next_value),
      .next_valid (next_valid),
      .value      (cell_value[i]),
      .valid      (cell_valid[i]),
      .lt         (cell_lt[i])
    );
  end

endmodule

// File: dv/sorter_ascending_load_emit_tb.sv
`timescale 1ns / 100ps

typedef struct packed {
  sal_pkg::value_t value;
  logic            last;
  logic            ovf;
} sorted_result_t;

typedef enum int {
  VM_WIDE,
  VM_NARROW,
  VM_EDGES
} value_mode_t;

class order_scoreboard;
  int unsigned capacity;
  sal_pkg::value_t loaded_values[$];
  bit dropped;
  sorted_result_t pending_sorted[$];
  int errors;
  int results_checked;
  int sets_closed;
  int overflow_sets;

  function new(int unsigned cap);
    capacity = cap;
    dropped = 0;
    errors = 0;
    results_checked = 0;
    sets_closed = 0;
    overflow_sets = 0;
  endfunction

  function void note_transfer(sal_pkg::value_t v, logic last_item);
    int pos;
    sorted_result_t r;
    if (loaded_values.size() >= capacity) begin
      dropped = 1;
    end else begin
      pos = loaded_values.size();
      while (pos > 0 && v < loaded_values[pos-1]) pos--;
      loaded_values.insert(pos, v);
    end
    if (last_item) begin
      foreach (loaded_values[k]) begin
        r.value = loaded_values[k];
        r.last = (k == loaded_values.size() - 1);
        r.ovf = dropped;
        pending_sorted.insert(pending_sorted.size(), r);
      end
      sets_closed++;
      if (dropped) overflow_sets++;
      loaded_values.delete();
      dropped = 0;
    end
  endfunction

  function void check_result(sal_pkg::value_t v, logic last, logic ovf);
    sorted_result_t exp_r;
    results_checked++;
    if (pending_sorted.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, sorted_value %0d last_result %0b overflow %0b",
               $time, v, last, ovf);
      return;
    end
    exp_r = pending_sorted.pop_front();
    if (v !== exp_r.value) begin
      errors++;
      $display("%0t: sorted_value expected %0d, got %0d", $time, exp_r.value, v);
    end
    if (last !== exp_r.last) begin
      errors++;
      $display("%0t: last_result expected %0b, got %0b", $time, exp_r.last, last);
    end
    if (ovf !== exp_r.ovf) begin
      errors++;
      $display("%0t: overflow expected %0b, got %0b", $time, exp_r.ovf, ovf);
    end
  endfunction

  function int pending();
    return pending_sorted.size();
  endfunction
endclass

module sorter_ascending_load_emit_tb;

  localparam int unsigned CAPACITY = 64;
  localparam int ITEM_TARGET = 330;
  localparam int CALM_AFTER = 290;
  localparam int LONG_HOLD = 150;
  localparam int DRAIN_CYCLES = 20;
  localparam sal_pkg::value_t VAL_MIN = 64'sh8000_0000_0000_0000;
  localparam sal_pkg::value_t VAL_MAX = 64'sh7fff_ffff_ffff_ffff;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  sal_pkg::value_t in_value;
  logic            in_last_item;
  logic            out_valid;
  logic            out_ready;
  sal_pkg::value_t out_sorted_value;
  logic            out_last_result;
  logic            out_overflow;

  order_scoreboard sb;
  int items_sent;
  int long_holds;
  bit calm;
  bit hold_armed;

  sorter_ascending_load_emit #(
    .MAX_ITEMS(CAPACITY)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_value        (in_value),
    .in_last_item    (in_last_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sorted_value(out_sorted_value),
    .out_last_result (out_last_result),
    .out_overflow    (out_overflow)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic sal_pkg::value_t next_value(value_mode_t mode);
    sal_pkg::value_t v;
    case (mode)
      VM_WIDE: begin
        v = {$urandom, $urandom};
      end
      VM_NARROW: begin
        v = sal_pkg::value_t'(int'($urandom_range(0, 16)) - 8);
      end
      default: begin
        case ($urandom_range(0, 7))
          0: v = VAL_MIN;
          1: v = VAL_MAX;
          2: v = VAL_MIN + sal_pkg::value_t'(1);
          3: v = VAL_MAX - sal_pkg::value_t'(1);
          4: v = '0;
          5: v = sal_pkg::value_t'(-1);
          6: v = sal_pkg::value_t'(1);
          default: v = {$urandom, $urandom};
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic send_item(sal_pkg::value_t v, logic last_item);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_value = v;
    in_last_item = last_item;
    do @(posedge clk); while (!in_ready);
    sb.note_transfer(v, last_item);
    items_sent++;
    if (items_sent >= CALM_AFTER) calm = 1'b1;
    @(negedge clk);
  endtask

  task automatic send_set(int n);
    value_mode_t mode;
    mode = value_mode_t'($urandom_range(0, 2));
    for (int i = 0; i < n; i++) send_item(next_value(mode), i == n - 1);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_sorted_value, out_last_result, out_overflow);
    end
  end

  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_armed && out_valid) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_armed = 1'b0;
        long_holds++;
        out_ready = 1'b1;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        out_ready = 1'b1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  initial begin
    #(1_000_000);
    $display("sorter_ascending_load_emit_tb NOT OK");
    $finish;
  end

  initial begin
    int set_idx;
    int n;
    sb = new(CAPACITY);
    items_sent = 0;
    long_holds = 0;
    calm = 1'b0;
    hold_armed = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_value = '0;
    in_last_item = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Single-element sets at both ends of the range, then mixed extremes,
    // ties, and already-ordered input in both directions.
    send_item(VAL_MIN, 1'b1);
    send_item(VAL_MAX, 1'b1);
    send_item('0, 1'b1);
    send_item(VAL_MAX, 1'b0);
    send_item(VAL_MIN, 1'b0);
    send_item('0, 1'b0);
    send_item(sal_pkg::value_t'(-1), 1'b0);
    send_item(sal_pkg::value_t'(1), 1'b1);
    repeat (3) send_item(sal_pkg::value_t'(7), 1'b0);
    send_item(sal_pkg::value_t'(7), 1'b1);
    for (int i = 5; i >= 1; i--) send_item(sal_pkg::value_t'(i), i == 1);
    send_item(sal_pkg::value_t'(-3), 1'b0);
    send_item(sal_pkg::value_t'(-2), 1'b0);
    send_item(sal_pkg::value_t'(-1), 1'b1);

    wait_drained();
    hold_armed = 1'b1;

    // Two sets run past capacity, one of them losing only its closing element.
    set_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      if (set_idx == 2) n = CAPACITY + 1;
      else if (set_idx == 9) n = CAPACITY + 3;
      else n = $urandom_range(1, 12);
      send_set(n);
      set_idx++;
    end
    in_valid = 1'b0;
    in_last_item = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Loaded %0d transfers into %0d sets, %0d of them past capacity.",
             items_sent, sb.sets_closed, sb.overflow_sets);
    $display("Checked %0d sorted results with %0d long output stall(s).",
             sb.results_checked, long_holds);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("sorter_ascending_load_emit_tb OK");
    end else begin
      $display("sorter_ascending_load_emit_tb NOT OK");
    end
    $finish;
  end

endmodule

// File: sorter_ascending_load_emit.f
src/sal_pkg.sv
src/sal_cell.sv
src/sorter_ascending_load_emit.sv
dv/sorter_ascending_load_emit_tb.sv
